/* sv/ir51_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir51_pkg: shared types for the IR to 8051 instruction encoder
// Operation and error codes, channel payloads and controller/datapath links.
// ----------------------------------------------------------------------------
package ir51_pkg;

    typedef enum logic [4:0] {
        OP_LDI   = 5'd0,
        OP_MOV   = 5'd1,
        OP_LOAD  = 5'd2,
        OP_ST    = 5'd3,
        OP_ADD   = 5'd4,
        OP_SUB   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_XOR   = 5'd8,
        OP_NOT   = 5'd9,
        OP_SHL   = 5'd10,
        OP_SHR   = 5'd11,
        OP_CMP   = 5'd12,
        OP_JMP   = 5'd13,
        OP_JZ    = 5'd14,
        OP_JNZ   = 5'd15,
        OP_CALL  = 5'd16,
        OP_RET   = 5'd17,
        OP_PUSH  = 5'd18,
        OP_POP   = 5'd19,
        OP_NOP   = 5'd20,
        OP_HLT   = 5'd21,
        OP_MUL   = 5'd22,
        OP_DIV   = 5'd23
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_REG   = 3'd1,
        ERR_IMM   = 3'd2,
        ERR_IND   = 3'd3,
        ERR_LABEL = 3'd4,
        ERR_REL   = 3'd5,
        ERR_UNSUP = 3'd6,
        ERR_SHIFT = 3'd7
    } err_t;

    // Encoding of the hardware limit on rotate count per instruction
    localparam int SHIFT_CAP = 8;

    typedef struct packed {
        logic [4:0]         req_type;
        logic [3:0]         first_reg;
        logic [3:0]         second_reg;
        logic               second_is_reg;
        logic signed [15:0] immediate;
        logic [15:0]        label_addr;
        logic               target_known;
    } req_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic [2:0] error_code;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic at_last;
    } dp_status_t;

endpackage : ir51_pkg
`default_nettype wire

/* sv/ir51_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir51_ctrl: encoder sequencer
// Takes one instruction, lets the datapath decode it, then steps out its bytes.
// ----------------------------------------------------------------------------
module ir51_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ir51_pkg::dp_status_t status,
    output ir51_pkg::ctrl_cmd_t      cmd
);
    import ir51_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_EMIT   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // advance one byte whenever the output register can take it
                cmd.emit = status.slot_free;
                if (status.slot_free && status.at_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : ir51_ctrl
`default_nettype wire

/* sv/ir51_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir51_datapath: instruction checks, byte generation and byte offset
// Holds the instruction, its error and length, the byte index and the
// output register.
// ----------------------------------------------------------------------------
module ir51_datapath #(
    parameter int MAX_SHIFT = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ir51_pkg::req_item_t req,
    input  wire ir51_pkg::ctrl_cmd_t cmd,
    output ir51_pkg::dp_status_t     status,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output ir51_pkg::rsp_item_t      rsp
);
    import ir51_pkg::*;

    localparam int SHIFT_LIMIT_INT = (MAX_SHIFT < SHIFT_CAP) ? MAX_SHIFT : SHIFT_CAP;
    localparam logic signed [15:0] SHIFT_LIMIT = 16'(SHIFT_LIMIT_INT);

    req_item_t   item_reg;
    err_t        err_reg, err_next;
    logic [3:0]  len_reg, len_next;
    logic [7:0]  disp_reg;
    logic [3:0]  idx_reg;
    logic [15:0] offset_reg;
    logic        out_valid_reg;
    rsp_item_t   out_reg;

    logic [2:0]         rd;
    logic [2:0]         r2;
    logic               sir;
    logic signed [15:0] imm;
    logic [7:0]         imm8;
    logic               imm_ok;
    logic               rd_bad;
    logic               r2_bad;
    logic               ind_bad;
    logic [15:0]        disp16;
    logic               rel_ok;
    logic [3:0]         shift_cnt;
    logic [7:0]         byte_c;
    logic [7:0]         rd_add;
    logic [7:0]         r2_add;
    logic [7:0]         alu_reg_op;
    logic [7:0]         alu_imm_op;
    logic               is_sub;
    logic [3:0]         j;
    logic               last_c;

    assign rd      = item_reg.first_reg[2:0];
    assign r2      = item_reg.second_reg[2:0];
    assign sir     = item_reg.second_is_reg;
    assign imm     = item_reg.immediate;
    assign imm8    = item_reg.immediate[7:0];
    assign rd_add  = {5'b0, rd};
    assign r2_add  = {5'b0, r2};
    assign imm_ok  = (imm >= -16'sd128) && (imm <= 16'sd255);
    assign rd_bad  = item_reg.first_reg[3];
    assign r2_bad  = item_reg.second_reg[3];
    assign ind_bad = (item_reg.second_reg > 4'd1);

    // displacement from the byte after a two-byte relative jump
    assign disp16 = item_reg.label_addr - (offset_reg + 16'd2);
    assign rel_ok = (disp16[15:7] == 9'h000) || (disp16[15:7] == 9'h1FF);

    assign shift_cnt = sir ? 4'd1 : ((imm > 16'sd0) ? imm[3:0] : 4'd0);

    // ---------------------------------------------------------------- checks
    always_comb
    begin
        err_next = ERR_OK;
        len_next = 4'd1;
        unique case (item_reg.req_type)
            OP_LDI:
            begin
                len_next = 4'd2;
                if (rd_bad)       err_next = ERR_REG;
                else if (!imm_ok) err_next = ERR_IMM;
            end
            OP_MOV:
            begin
                len_next = 4'd2;
                if (rd_bad || r2_bad) err_next = ERR_REG;
            end
            OP_LOAD, OP_ST:
            begin
                len_next = 4'd2;
                if (rd_bad)       err_next = ERR_REG;
                else if (ind_bad) err_next = ERR_IND;
            end
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_CMP:
            begin
                len_next = (sir ? 4'd3 : 4'd4)
                         + ((item_reg.req_type == OP_SUB) ? 4'd1 : 4'd0);
                if (rd_bad)              err_next = ERR_REG;
                else if (sir && r2_bad)  err_next = ERR_REG;
                else if (!sir && !imm_ok) err_next = ERR_IMM;
            end
            OP_MUL, OP_DIV:
            begin
                len_next = 4'd6;
                if (rd_bad)               err_next = ERR_REG;
                else if (sir && r2_bad)   err_next = ERR_REG;
                else if (!sir && !imm_ok) err_next = ERR_IMM;
            end
            OP_NOT:
            begin
                len_next = 4'd3;
                if (rd_bad) err_next = ERR_REG;
            end
            OP_SHL, OP_SHR:
            begin
                len_next = shift_cnt + 4'd2;
                if (rd_bad)                      err_next = ERR_REG;
                else if (sir && r2_bad)          err_next = ERR_REG;
                else if (!sir && (imm > SHIFT_LIMIT)) err_next = ERR_SHIFT;
            end
            OP_JMP, OP_CALL:
            begin
                len_next = 4'd3;
                if (!item_reg.target_known) err_next = ERR_LABEL;
            end
            OP_JZ, OP_JNZ:
            begin
                len_next = 4'd2;
                if (!item_reg.target_known) err_next = ERR_LABEL;
                else if (!rel_ok)           err_next = ERR_REL;
            end
            OP_PUSH, OP_POP:
            begin
                len_next = 4'd2;
                if (rd_bad) err_next = ERR_REG;
            end
            OP_HLT:
            begin
                len_next = 4'd2;
            end
            OP_RET, OP_NOP:
            begin
                len_next = 4'd1;
            end
            default:
            begin
                err_next = ERR_UNSUP;
            end
        endcase
        if (err_next != ERR_OK)
        begin
            len_next = 4'd1;
        end
    end

    // ------------------------------------------------------- byte generation
    always_comb
    begin
        alu_reg_op = 8'h28;
        alu_imm_op = 8'h24;
        unique case (item_reg.req_type)
            OP_SUB:
            begin
                alu_reg_op = 8'h98;
                alu_imm_op = 8'h94;
            end
            OP_AND:
            begin
                alu_reg_op = 8'h58;
                alu_imm_op = 8'h54;
            end
            OP_OR:
            begin
                alu_reg_op = 8'h48;
                alu_imm_op = 8'h44;
            end
            OP_XOR:
            begin
                alu_reg_op = 8'h68;
                alu_imm_op = 8'h64;
            end
            default:
            begin
                alu_reg_op = 8'h28;
                alu_imm_op = 8'h24;
            end
        endcase
    end

    assign is_sub = (item_reg.req_type == OP_SUB);
    assign j      = is_sub ? (idx_reg - 4'd1) : idx_reg;
    assign last_c = (idx_reg == (len_reg - 4'd1));

    always_comb
    begin
        byte_c = 8'h00;
        unique case (item_reg.req_type)
            OP_LDI:   byte_c = (idx_reg == 4'd0) ? (8'h78 + rd_add) : imm8;
            OP_MOV:   byte_c = (idx_reg == 4'd0) ? (8'hE8 + r2_add) : (8'hF8 + rd_add);
            OP_LOAD:  byte_c = (idx_reg == 4'd0) ? (8'hE6 + r2_add) : (8'hF8 + rd_add);
            OP_ST:    byte_c = (idx_reg == 4'd0) ? (8'hE8 + rd_add) : (8'hF6 + r2_add);
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
            begin
                if (is_sub && (idx_reg == 4'd0))
                begin
                    byte_c = 8'hC3;
                end
                else
                begin
                    unique case (j)
                        4'd0:    byte_c = 8'hE8 + rd_add;
                        4'd1:    byte_c = sir ? (alu_reg_op + r2_add) : alu_imm_op;
                        4'd2:    byte_c = sir ? (8'hF8 + rd_add) : imm8;
                        default: byte_c = 8'hF8 + rd_add;
                    endcase
                end
            end
            OP_NOT:
            begin
                unique case (idx_reg)
                    4'd0:    byte_c = 8'hE8 + rd_add;
                    4'd1:    byte_c = 8'hF4;
                    default: byte_c = 8'hF8 + rd_add;
                endcase
            end
            OP_SHL, OP_SHR:
            begin
                priority if (idx_reg == 4'd0)
                    byte_c = 8'hE8 + rd_add;
                else if (last_c)
                    byte_c = 8'hF8 + rd_add;
                else
                    byte_c = (item_reg.req_type == OP_SHL) ? 8'h23 : 8'h03;
            end
            OP_CMP:
            begin
                unique case (idx_reg)
                    4'd0:    byte_c = 8'hE8 + rd_add;
                    4'd1:    byte_c = sir ? 8'hC3 : 8'hB4;
                    4'd2:    byte_c = sir ? (8'h98 + r2_add) : imm8;
                    default: byte_c = 8'h00;
                endcase
            end
            OP_JMP, OP_CALL:
            begin
                unique case (idx_reg)
                    4'd0:    byte_c = (item_reg.req_type == OP_JMP) ? 8'h02 : 8'h12;
                    4'd1:    byte_c = item_reg.label_addr[15:8];
                    default: byte_c = item_reg.label_addr[7:0];
                endcase
            end
            OP_JZ, OP_JNZ:
            begin
                if (idx_reg == 4'd0)
                    byte_c = (item_reg.req_type == OP_JZ) ? 8'h60 : 8'h70;
                else
                    byte_c = disp_reg;
            end
            OP_RET:  byte_c = 8'h22;
            OP_PUSH: byte_c = (idx_reg == 4'd0) ? 8'hC0 : rd_add;
            OP_POP:  byte_c = (idx_reg == 4'd0) ? 8'hD0 : rd_add;
            OP_NOP:  byte_c = 8'h00;
            OP_HLT:  byte_c = (idx_reg == 4'd0) ? 8'h80 : 8'hFE;
            OP_MUL, OP_DIV:
            begin
                unique case (idx_reg)
                    4'd0:    byte_c = sir ? (8'hE8 + r2_add) : 8'h75;
                    4'd1:    byte_c = sir ? 8'hF5 : 8'hF0;
                    4'd2:    byte_c = sir ? 8'hF0 : imm8;
                    4'd3:    byte_c = 8'hE8 + rd_add;
                    4'd4:    byte_c = (item_reg.req_type == OP_MUL) ? 8'hA4 : 8'h84;
                    default: byte_c = 8'hF8 + rd_add;
                endcase
            end
            default: byte_c = 8'h00;
        endcase
        if (err_reg != ERR_OK)
        begin
            byte_c = 8'h00;
        end
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.decode)
        begin
            len_reg  <= len_next;
            disp_reg <= disp16[7:0];
        end
        if (cmd.emit)
        begin
            out_reg.code_byte  <= byte_c;
            out_reg.last_byte  <= last_c;
            out_reg.error_code <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= ERR_OK;
            idx_reg       <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
            begin
                err_reg <= err_next;
                idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
            // commit the length of an error-free instruction once its last byte is out
            if (cmd.emit && last_c && (err_reg == ERR_OK))
            begin
                offset_reg <= offset_reg + {12'b0, len_reg};
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status    = dp_status_t'{slot_free: (!out_valid_reg || rsp_ready),
                                    at_last: last_c};
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule : ir51_datapath
`default_nettype wire

/* sv/ir_to_8051_instruction_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_to_8051_instruction_encoder: neutral IR instruction to 8051 machine code
// One instruction in, its code bytes out one per transfer, last byte marked.
// ----------------------------------------------------------------------------
//  channel  signals                    payload      per transfer
//  req      req_valid / req_ready      req_item_t   one IR instruction
//  rsp      rsp_valid / rsp_ready      rsp_item_t   one code byte or one error
//
//  An instruction is accepted, then checked and decoded, and then its
//  N bytes (1 to 10; 1 on error) are stepped through the output register.
//  The emit sequencer sets the rate: one byte per cycle unless rsp_ready holds it.
//  rsp_ready low holds the sequencer; the output register keeps its byte.
//  Reset clears the byte offset, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module ir_to_8051_instruction_encoder #(
    parameter int MAX_SHIFT = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ir51_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output ir51_pkg::rsp_item_t      rsp
);
    import ir51_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ir51_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ir51_datapath #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule : ir_to_8051_instruction_encoder
`default_nettype wire
